FILE: rtl/core/pts_pkg.sv
// Package for the pan/tilt slew tracker: fixed-point constants, register
// indexes and reset values, the control word type and the microcode table.
// No dependencies; used by pts_datapath and pan_tilt_slew_tracker.
package pts_pkg;

  // Angles are Q3.12 radians, the time step is Q0.16 seconds.
  localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
  localparam logic signed [17:0] PI_Q12      = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
  localparam logic        [15:0] DT_MIN      = 16'd655;
  localparam logic        [15:0] DT_MAX      = 16'd6554;

  // Configuration register indexes.
  localparam logic [7:0] REG_MAX_RATE_PAN  = 8'd0;
  localparam logic [7:0] REG_MAX_RATE_TILT = 8'd1;
  localparam logic [7:0] REG_RATE_GAIN     = 8'd2;
  localparam logic [7:0] REG_AIM_THRESHOLD = 8'd3;

  // Configuration reset values.
  localparam logic [14:0] MAX_RATE_RST      = 15'd6144;
  localparam logic [7:0]  RATE_GAIN_RST     = 8'd20;
  localparam logic [11:0] AIM_THRESHOLD_RST = 12'd205;

  // Program length; the step counter wraps over it.
  localparam int unsigned PROG_LEN = 8;
  localparam int unsigned STEP_W   = $clog2(PROG_LEN);

  // Multiplier operand A source.
  typedef enum logic [1:0] {
    A_EPAN,
    A_ETILT,
    A_THR,
    A_RATE
  } a_sel_e;

  // Multiplier operand B source.
  typedef enum logic [1:0] {
    B_SAME,
    B_GAIN,
    B_DTC
  } b_sel_e;

  // Accumulator operation for the squared aim distance.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // Angle register written by the step.
  typedef enum logic [1:0] {
    ANG_NONE,
    ANG_PAN,
    ANG_TILT
  } ang_wr_e;

  // Sequencer action after the step.
  typedef enum logic {
    SEQ_NEXT,
    SEQ_END
  } seq_e;

  // One control word of the microprogram.
  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    fire_en;
    logic    rate_en;
    logic    lim_tilt;
    ang_wr_e ang_wr;
    seq_e    seq;
  } ctrl_t;

  // Microprogram. The product register always holds the result of the
  // multiplication issued one step earlier.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{a_sel: A_EPAN, b_sel: B_SAME, acc_op: ACC_HOLD, fire_en: 1'b0,
          rate_en: 1'b0, lim_tilt: 1'b0, ang_wr: ANG_NONE, seq: SEQ_NEXT};
    unique case (step)
      // Square the pan error.
      3'd0: c.a_sel = A_EPAN;
      // Square the tilt error, load the pan square.
      3'd1: begin
        c.a_sel  = A_ETILT;
        c.acc_op = ACC_LOAD;
      end
      // Square the threshold, add the tilt square.
      3'd2: begin
        c.a_sel  = A_THR;
        c.acc_op = ACC_ADD;
      end
      // Compare distance against threshold; pan error times gain.
      3'd3: begin
        c.a_sel   = A_EPAN;
        c.b_sel   = B_GAIN;
        c.fire_en = 1'b1;
      end
      // Clamp the pan rate; tilt error times gain.
      3'd4: begin
        c.a_sel   = A_ETILT;
        c.b_sel   = B_GAIN;
        c.rate_en = 1'b1;
      end
      // Pan rate times time step; clamp the tilt rate.
      3'd5: begin
        c.a_sel    = A_RATE;
        c.b_sel    = B_DTC;
        c.rate_en  = 1'b1;
        c.lim_tilt = 1'b1;
      end
      // Update pan; tilt rate times time step.
      3'd6: begin
        c.a_sel  = A_RATE;
        c.b_sel  = B_DTC;
        c.ang_wr = ANG_PAN;
      end
      // Update tilt and hand off the result.
      3'd7: begin
        c.ang_wr = ANG_TILT;
        c.seq    = SEQ_END;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/pts_datapath.sv
// Datapath of the pan/tilt slew tracker: operand registers, the shared
// multiplier, accumulator, rate clamp and angle update, driven by ctrl_t.
// Depends on pts_pkg.
module pts_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [15:0]          time_step_i,
  input  logic signed [15:0]   goal_pan_i,
  input  logic signed [15:0]   goal_tilt_i,
  input  logic                 step_en_i,
  input  pts_pkg::ctrl_t       ctrl_i,
  input  logic [14:0]          max_rate_pan_i,
  input  logic [14:0]          max_rate_tilt_i,
  input  logic [7:0]           rate_gain_i,
  input  logic [11:0]          aim_threshold_i,
  output logic signed [15:0]   new_pan_o,
  output logic signed [15:0]   new_tilt_o,
  output logic                 fire_o
);

  logic signed [15:0] pan_q, pan_d, tilt_q, tilt_d;
  logic signed [16:0] err_pan_q, err_tilt_q;
  logic [12:0]        dtc_q, dtc_d;
  logic signed [35:0] prod_q, prod_d;
  logic [32:0]        acc_q, acc_d;
  logic               fire_q, fire_d;
  logic signed [15:0] rate_q, rate_d;
  logic signed [17:0] op_a, op_b;
  logic signed [35:0] lim;
  logic signed [35:0] rounded;
  logic signed [15:0] cur_ang;
  logic signed [17:0] sum, wrapped;
  logic signed [15:0] ang_new;

  // Clamp the time step at load.
  always_comb begin
    if (time_step_i < pts_pkg::DT_MIN) begin
      dtc_d = pts_pkg::DT_MIN[12:0];
    end else if (time_step_i > pts_pkg::DT_MAX) begin
      dtc_d = pts_pkg::DT_MAX[12:0];
    end else begin
      dtc_d = time_step_i[12:0];
    end
  end

  // Operand registers, loaded when a transaction is accepted.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_pan_q  <= {goal_pan_i[15], goal_pan_i} - {pan_q[15], pan_q};
      err_tilt_q <= {goal_tilt_i[15], goal_tilt_i} - {tilt_q[15], tilt_q};
      dtc_q      <= dtc_d;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl_i.a_sel)
      pts_pkg::A_EPAN:  op_a = {err_pan_q[16], err_pan_q};
      pts_pkg::A_ETILT: op_a = {err_tilt_q[16], err_tilt_q};
      pts_pkg::A_THR:   op_a = {6'd0, aim_threshold_i};
      pts_pkg::A_RATE:  op_a = {{2{rate_q[15]}}, rate_q};
      default:          op_a = '0;
    endcase
    unique case (ctrl_i.b_sel)
      pts_pkg::B_SAME: op_b = op_a;
      pts_pkg::B_GAIN: op_b = {10'd0, rate_gain_i};
      pts_pkg::B_DTC:  op_b = {5'd0, dtc_q};
      default:         op_b = '0;
    endcase
    prod_d = op_a * op_b;
  end

  // Squared distance accumulation and the fire compare.
  always_comb begin
    unique case (ctrl_i.acc_op)
      pts_pkg::ACC_LOAD: acc_d = prod_q[32:0];
      pts_pkg::ACC_ADD:  acc_d = acc_q + prod_q[32:0];
      default:           acc_d = acc_q;
    endcase
    fire_d = ctrl_i.fire_en ? (acc_q < {9'd0, prod_q[23:0]}) : fire_q;
  end

  // Clamp the proportional rate to the selected axis limit.
  always_comb begin
    lim = ctrl_i.lim_tilt ? {21'd0, max_rate_tilt_i} : {21'd0, max_rate_pan_i};
    if (!ctrl_i.rate_en) begin
      rate_d = rate_q;
    end else if (prod_q > lim) begin
      rate_d = lim[15:0];
    end else if (prod_q < -lim) begin
      rate_d = -lim[15:0];
    end else begin
      rate_d = prod_q[15:0];
    end
  end

  // Round the angle step, add it, wrap above pi and saturate below.
  always_comb begin
    rounded = prod_q + 36'sd32768;
    cur_ang = (ctrl_i.ang_wr == pts_pkg::ANG_TILT) ? tilt_q : pan_q;
    sum     = {{2{cur_ang[15]}}, cur_ang} + rounded[33:16];
    wrapped = (sum > pts_pkg::PI_Q12) ? sum - pts_pkg::TWO_PI_Q12 : sum;
    if (wrapped < -18'sd32768) begin
      ang_new = -16'sd32768;
    end else begin
      ang_new = wrapped[15:0];
    end
    pan_d  = (ctrl_i.ang_wr == pts_pkg::ANG_PAN) ? ang_new : pan_q;
    tilt_d = (ctrl_i.ang_wr == pts_pkg::ANG_TILT) ? ang_new : tilt_q;
  end

  // Working registers advance one microprogram step at a time.
  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      rate_q <= rate_d;
      fire_q <= fire_d;
    end
  end

  // Angle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q  <= pts_pkg::HALF_PI_Q12;
      tilt_q <= pts_pkg::HALF_PI_Q12;
    end else if (step_en_i) begin
      pan_q  <= pan_d;
      tilt_q <= tilt_d;
    end
  end

  // On the final step pan is already updated and tilt is being written.
  assign new_pan_o  = pan_q;
  assign new_tilt_o = ang_new;
  assign fire_o     = fire_q;

endmodule

FILE: rtl/core/pan_tilt_slew_tracker.sv
// Pan/tilt slew tracker top level: stream handshakes, configuration
// registers, microcode sequencer and result register.
// Depends on pts_pkg and pts_datapath.
//
// Usage: each transaction on the s_axis channel is one control tick carrying
// a time step and goal pan/tilt angles. The block moves both angles toward
// the goal at a clamped proportional rate and returns one m_axis transaction
// with the new angles and a fire flag computed from the angles held before
// the tick. Configuration writes on the cfg channel are always taken and must
// only be issued while no tick is in flight.
// The result is registered at the end of the last of the eight program
// steps. A new tick is taken only after the previous program ends: eight
// steps of a program that shares a single 18x18 multiplier across the
// distance and both axes, then s_axis_tready goes high and the next tick
// is taken.
// s_axis_tready is low while the program runs; a new tick is taken while a
// finished result still waits on m_axis. If the receiver stalls, the program
// holds on its last step until the result register frees up.
// Reset restores both angles to pi/2 and the registers to their defaults.
module pan_tilt_slew_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields from bit 0: time_step[15:0], goal_pan[31:16], goal_tilt[47:32].
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: new_pan[15:0], new_tilt[31:16], fire[32], zero pad.
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  logic [14:0] max_rate_pan_q, max_rate_tilt_q;
  logic [7:0]  rate_gain_q;
  logic [11:0] aim_threshold_q;

  logic                       busy_q, busy_d;
  logic [pts_pkg::STEP_W-1:0] step_q, step_d;
  pts_pkg::ctrl_t             ctrl;
  logic                       accept, step_en, finish;

  logic                       out_valid_q, out_valid_d;
  logic signed [15:0]         out_pan_q, out_tilt_q;
  logic                       out_fire_q;
  logic signed [15:0]         res_pan, res_tilt;
  logic                       res_fire;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_pan_q  <= pts_pkg::MAX_RATE_RST;
      max_rate_tilt_q <= pts_pkg::MAX_RATE_RST;
      rate_gain_q     <= pts_pkg::RATE_GAIN_RST;
      aim_threshold_q <= pts_pkg::AIM_THRESHOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pts_pkg::REG_MAX_RATE_PAN:  max_rate_pan_q  <= cfg_data_i;
        pts_pkg::REG_MAX_RATE_TILT: max_rate_tilt_q <= cfg_data_i;
        pts_pkg::REG_RATE_GAIN:     rate_gain_q     <= cfg_data_i[7:0];
        pts_pkg::REG_AIM_THRESHOLD: aim_threshold_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Microcode sequencer: fetch the control word, hold on the last step
  // while the result register is still occupied.
  assign ctrl          = pts_pkg::ucode(step_q);
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step_en       = busy_q && !(ctrl.seq == pts_pkg::SEQ_END &&
                                     out_valid_q && !m_axis_tready);
  assign finish        = step_en && (ctrl.seq == pts_pkg::SEQ_END);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (accept) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (finish) begin
      busy_d = 1'b0;
      step_d = '0;
    end else if (step_en) begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  pts_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .time_step_i     (s_axis_tdata[15:0]),
    .goal_pan_i      (s_axis_tdata[31:16]),
    .goal_tilt_i     (s_axis_tdata[47:32]),
    .step_en_i       (step_en),
    .ctrl_i          (ctrl),
    .max_rate_pan_i  (max_rate_pan_q),
    .max_rate_tilt_i (max_rate_tilt_q),
    .rate_gain_i     (rate_gain_q),
    .aim_threshold_i (aim_threshold_q),
    .new_pan_o       (res_pan),
    .new_tilt_o      (res_tilt),
    .fire_o          (res_fire)
  );

  // Result register toward the master side.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_pan_q  <= res_pan;
      out_tilt_q <= res_tilt;
      out_fire_q <= res_fire;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_fire_q, out_tilt_q, out_pan_q};

`ifndef SYNTHESIS
  // An accepted tick starts the program at its first step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && step_q == '0)
    else $error("sequencer did not start after an accepted tick");

  // A result appears only when the program completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(finish))
    else $error("result raised without a completed program");

  // The program holds on its last step while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && ctrl.seq == pts_pkg::SEQ_END && out_valid_q && !m_axis_tready)
      |=> busy_q && $stable(step_q))
    else $error("program left its last step during a stall");

  // A zero threshold never lets fire through.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[32]) |-> aim_threshold_q != 12'd0)
    else $error("fire set with a zero aim threshold");
`endif

endmodule
